>>> sv/udbm_pkg.sv
// ----------------------------------------------------------------------------
// udbm_pkg
// Types, constants and helper functions shared by the url decode and
// blacklist matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package udbm_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int RAW_LIMIT    = BUFFER_BYTES - 1;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);

  localparam int PAT_N  = 12;
  localparam int HIST_N = 11;
  localparam int WIN_N  = HIST_N + 1;
  localparam int IDX_W  = 4;

  localparam logic [IDX_W-1:0] MATCH_NONE = IDX_W'(PAT_N);

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // patterns right aligned, last character in the low byte
  typedef logic [WIN_N*8-1:0] pat_t;

  localparam pat_t PAT_TEXT [PAT_N] = '{
    "<script>", "javascript:", "onerror=", "OR 1=1",
    "DROP TABLE", "UNION SELECT", "../", "/etc/passwd",
    "cmd.exe", "/admin", "/phpmyadmin", "/.env"
  };

  localparam logic [3:0] PAT_LEN [PAT_N] = '{
    4'd8, 4'd11, 4'd8, 4'd6, 4'd10, 4'd12, 4'd3, 4'd11, 4'd7, 4'd6, 4'd11, 4'd5
  };

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HELD = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic             allowed;
    logic [IDX_W-1:0] match_index;
  } out_t;

  // up to two decoded bytes per transaction, e0 is the older one
  typedef struct packed {
    logic       e0_v;
    logic [7:0] e0_b;
    logic       e1_v;
    logic [7:0] e1_b;
  } emit_t;

  typedef struct packed {
    logic clear;
    logic sh1;
    logic sh2;
  } hist_ctl_t;

  function automatic logic [3:0] hex_val_f(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end
    return v;
  endfunction

  // window byte 0 is the newest decoded byte
  function automatic logic [PAT_N-1:0] match_f(input logic [WIN_N-1:0][7:0] win);
    logic [PAT_N-1:0] hit;
    logic             ok;
    hit = '0;
    for (int p = 0; p < PAT_N; p++) begin
      ok = 1'b1;
      for (int k = 0; k < WIN_N; k++) begin
        if (k < int'(PAT_LEN[p]) && win[k] != PAT_TEXT[p][k*8 +: 8]) begin
          ok = 1'b0;
        end
      end
      hit[p] = ok;
    end
    return hit;
  endfunction

  function automatic logic [IDX_W-1:0] prio_f(input logic [PAT_N-1:0] h);
    logic [IDX_W-1:0] idx;
    idx = MATCH_NONE;
    for (int p = PAT_N - 1; p >= 0; p--) begin
      if (h[p]) begin
        idx = IDX_W'(p);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> sv/udbm_decode.sv
// ----------------------------------------------------------------------------
// udbm_decode
// Percent and plus decoder front end with byte limit and end-of-string
// handling; yields up to two decoded bytes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module udbm_decode
  import udbm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire in_t   in_data_i,
  output emit_t      emit_o
);

  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(RAW_LIMIT);
  localparam logic [CNT_W-1:0] FINAL_CNT = CNT_W'(RAW_LIMIT - 1);

  phase_e           ph_q, ph_d;
  logic [7:0]       held_q, held_d;
  logic             ended_q, ended_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin;
  logic [7:0]       dec;
  logic [7:0]       raw;
  emit_t            em;

  assign raw = in_data_i.raw_byte;
  assign dec = {hex_val_f(held_q), hex_val_f(raw)};

  always_comb begin
    ph_d    = ph_q;
    held_d  = held_q;
    ended_d = ended_q;
    cnt_d   = cnt_q;
    em      = '0;
    fin     = 1'b0;
    if (accept_i) begin
      fin = in_data_i.last;
      if (!ended_q && cnt_q != LIMIT_CNT) begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FINAL_CNT) begin
          fin = 1'b1;
        end
        if (raw == 8'd0) begin
          fin = 1'b1;
        end else begin
          case (ph_q)
            PH_IDLE: begin
              if (raw == CH_PCT) begin
                ph_d = PH_PCT;
              end else begin
                em.e0_v = 1'b1;
                em.e0_b = (raw == CH_PLUS) ? CH_SPACE : raw;
              end
            end
            PH_PCT: begin
              held_d = raw;
              ph_d   = PH_HELD;
            end
            PH_HELD: begin
              ph_d   = PH_IDLE;
              held_d = 8'd0;
              if (dec == 8'd0) begin
                ended_d = 1'b1;
              end else begin
                em.e0_v = 1'b1;
                em.e0_b = dec;
              end
            end
            default: begin
              ph_d = PH_IDLE;
            end
          endcase
        end
      end
      // flush an unfinished escape as literal text
      if (fin) begin
        if (!ended_d) begin
          if (ph_d != PH_IDLE) begin
            em.e0_v = 1'b1;
            em.e0_b = CH_PCT;
          end
          if (ph_d == PH_HELD) begin
            em.e1_v = 1'b1;
            em.e1_b = (held_d == CH_PLUS) ? CH_SPACE : held_d;
          end
        end
        ph_d    = PH_IDLE;
        held_d  = 8'd0;
        ended_d = 1'b1;
      end
      if (in_data_i.last) begin
        ph_d    = PH_IDLE;
        held_d  = 8'd0;
        ended_d = 1'b0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      held_q  <= 8'd0;
      ended_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      ph_q    <= ph_d;
      held_q  <= held_d;
      ended_q <= ended_d;
      cnt_q   <= cnt_d;
    end
  end

  assign emit_o = em;

endmodule

`default_nettype wire

>>> sv/udbm_cell.sv
// ----------------------------------------------------------------------------
// udbm_cell
// One history cell of the decoded byte chain; clears, or shifts by zero, one
// or two positions per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module udbm_cell
  import udbm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hist_ctl_t  ctl_i,
  input  wire logic [7:0] nb1_i,
  input  wire logic [7:0] nb2_i,
  output logic      [7:0] q_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctl_i.sh2) begin
      byte_d = nb2_i;
    end else if (ctl_i.sh1) begin
      byte_d = nb1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign q_o = byte_q;

endmodule

`default_nettype wire

>>> sv/udbm_match.sv
// ----------------------------------------------------------------------------
// udbm_match
// Parallel pattern compare on each decoded byte against the history chain,
// with sticky hit flags.
// ----------------------------------------------------------------------------
`default_nettype none

module udbm_match
  import udbm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire emit_t                  emit_i,
  input  wire logic [HIST_N-1:0][7:0] hist_i,
  input  wire logic                   clear_i,
  output logic      [PAT_N-1:0]       hits_o
);

  logic [PAT_N-1:0]       hit_q, hit_d;
  logic [WIN_N-1:0][7:0]  win0, win1;
  logic [PAT_N-1:0]       new0, new1;
  logic [PAT_N-1:0]       hits_now;

  assign win0 = {hist_i, emit_i.e0_b};
  assign win1 = {hist_i[HIST_N-2:0], emit_i.e0_b, emit_i.e1_b};

  assign new0 = emit_i.e0_v ? match_f(win0) : '0;
  assign new1 = emit_i.e1_v ? match_f(win1) : '0;

  assign hits_now = hit_q | new0 | new1;
  assign hit_d    = clear_i ? '0 : hits_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hits_o = hits_now;

endmodule

`default_nettype wire

>>> sv/url_decode_blacklist_matcher_core.sv
// ----------------------------------------------------------------------------
// url_decode_blacklist_matcher_core
// URL decoder with a twelve pattern blacklist matcher over the decoded text.
// ----------------------------------------------------------------------------
// usage
//   input channel carries one raw request byte per transaction plus a last
//   flag; one transaction per cycle while ready, every byte decoded and
//   matched in the cycle it is taken
//   only the transaction flagged last yields a result: allowed and the lowest
//   matched pattern index (12 when none); it is captured in the output
//   register when the last byte is accepted, clearing all request state
//   decoded history lives in a chain of eleven byte cells that shifts by up
//   to two bytes per cycle (a flushed unfinished escape gives two bytes)
//   non-last bytes are accepted even while a result waits; a last byte waits
//   only while the output register is full and not being taken
//   reset clears decoder, history, hit flags and the output valid flag, not
//   the output data register; the block is ready straight after reset
// ----------------------------------------------------------------------------
`default_nettype none

module url_decode_blacklist_matcher_core
  import udbm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic                   accept;
  logic                   last_acc;
  emit_t                  emit;
  hist_ctl_t              hctl;
  logic [HIST_N-1:0][7:0] hist;
  logic [PAT_N-1:0]       hits;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i || !in_data_i.last;
  assign accept     = in_valid_i && in_ready_o;
  assign last_acc   = accept && in_data_i.last;

  udbm_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .emit_o    (emit)
  );

  assign hctl.clear = last_acc;
  assign hctl.sh2   = emit.e1_v;
  assign hctl.sh1   = emit.e0_v && !emit.e1_v;

  for (genvar k = 0; k < HIST_N; k++) begin : g_cell
    logic [7:0] nb1, nb2;
    if (k == 0) begin : g_head
      assign nb1 = emit.e0_b;
      assign nb2 = emit.e1_b;
    end else if (k == 1) begin : g_second
      assign nb1 = hist[0];
      assign nb2 = emit.e0_b;
    end else begin : g_body
      assign nb1 = hist[k-1];
      assign nb2 = hist[k-2];
    end
    udbm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (hctl),
      .nb1_i  (nb1),
      .nb2_i  (nb2),
      .q_o    (hist[k])
    );
  end

  udbm_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .hist_i  (hist),
    .clear_i (last_acc),
    .hits_o  (hits)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (last_acc) begin
      out_valid_d       = 1'b1;
      out_d.allowed     = (hits == '0);
      out_d.match_index = prio_f(hits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sv/udbm_checker.sv
// ----------------------------------------------------------------------------
// udbm_checker
// Port level checks for the url decode blacklist matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module udbm_checker
  import udbm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  // allowed exactly when no pattern index is reported
  a_allowed_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.allowed == (out_data_o.match_index == MATCH_NONE)))
    else $error("allowed and match index disagree");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_index <= MATCH_NONE)
    else $error("match index out of range");

  // every accepted last byte gives a result next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> out_valid_o)
    else $error("no result after last byte");

endmodule

bind url_decode_blacklist_matcher_core udbm_checker u_udbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
